// File: rtl/core/wpm_pkg.sv
package wpm_pkg;

  // Default pattern store depth
  localparam int MAX_PATTERN_DEF = 32;

  // Field widths
  localparam int CHAR_W = 8;
  localparam int FUNC_W = 2;
  localparam int POS_W  = 5;

  // Configuration port geometry (64-bit registers at 8-byte strides)
  localparam int CFG_DW    = 64;
  localparam int CFG_AW    = 6;
  localparam int REG_IDX_W = 3;
  localparam int REG_IDX_LSB = 3;

  // Request function codes
  localparam logic [FUNC_W-1:0] FUNC_LOAD = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_SUBJ = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_FIN  = 2'd2;

  // Register indexes
  localparam logic [REG_IDX_W-1:0] REG_MASK0 = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_MASK1 = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_MASK2 = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_MASK3 = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_LIMIT = 3'd4;

  // Pattern metacharacters
  localparam logic [CHAR_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [CHAR_W-1:0] CH_QUEST = 8'h3F;
  localparam logic [CHAR_W-1:0] CH_OPT   = 8'h5E;

  // Match phase
  typedef enum logic [1:0] {
    PH_RUN  = 2'd0,
    PH_FAIL = 2'd1,
    PH_TAIL = 2'd2
  } phase_t;

endpackage

// File: rtl/core/wpm_in_if.sv
interface wpm_in_if;
  logic                          valid;
  logic                          ready;
  logic [wpm_pkg::FUNC_W-1:0]    func;
  logic [wpm_pkg::CHAR_W-1:0]    char_value;
  logic [wpm_pkg::POS_W-1:0]     pattern_pos;

  modport source (output valid, func, char_value, pattern_pos, input ready);
  modport sink   (input valid, func, char_value, pattern_pos, output ready);
endinterface

// File: rtl/core/wpm_out_if.sv
interface wpm_out_if;
  logic valid;
  logic ready;
  logic match;

  modport source (output valid, match, input ready);
  modport sink   (input valid, match, output ready);
endinterface

// File: rtl/core/wpm_ram.sv
module wpm_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    rdata_r <= mem_r[raddr];
  end

  assign rdata = rdata_r;

endmodule

// File: rtl/core/wpm_cfg.sv
module wpm_cfg (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [wpm_pkg::CFG_AW-1:0]    paddr,
  input  logic [wpm_pkg::CFG_DW-1:0]    pwdata,
  output logic [wpm_pkg::CFG_DW-1:0]    prdata,
  output logic                          pready,
  input  logic [wpm_pkg::CHAR_W-1:0]    query_char,
  output logic                          query_auth
);

  logic [wpm_pkg::CFG_DW-1:0]    mask0_r, mask1_r, mask2_r, mask3_r;
  logic                          limit_r;
  logic [wpm_pkg::REG_IDX_W-1:0] idx;
  logic                          wr_en;
  logic [4*wpm_pkg::CFG_DW-1:0]  allowed;

  assign idx    = paddr[wpm_pkg::REG_IDX_LSB +: wpm_pkg::REG_IDX_W];
  assign wr_en  = psel & penable & pwrite;
  assign pready = 1'b1;

  // Register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mask0_r <= '0;
      mask1_r <= '0;
      mask2_r <= '0;
      mask3_r <= '0;
      limit_r <= 1'b0;
    end else if (wr_en) begin
      case (idx)
        wpm_pkg::REG_MASK0: mask0_r <= pwdata;
        wpm_pkg::REG_MASK1: mask1_r <= pwdata;
        wpm_pkg::REG_MASK2: mask2_r <= pwdata;
        wpm_pkg::REG_MASK3: mask3_r <= pwdata;
        wpm_pkg::REG_LIMIT: limit_r <= pwdata[0];
        default: ;
      endcase
    end
  end

  // Read mux
  always_comb begin
    case (idx)
      wpm_pkg::REG_MASK0: prdata = mask0_r;
      wpm_pkg::REG_MASK1: prdata = mask1_r;
      wpm_pkg::REG_MASK2: prdata = mask2_r;
      wpm_pkg::REG_MASK3: prdata = mask3_r;
      wpm_pkg::REG_LIMIT: prdata = {{(wpm_pkg::CFG_DW-1){1'b0}}, limit_r};
      default:            prdata = '0;
    endcase
  end

  // Authorised-character lookup
  assign allowed    = {mask3_r, mask2_r, mask1_r, mask0_r};
  assign query_auth = !limit_r || allowed[query_char];

endmodule

// File: rtl/core/wpm_seq.sv
module wpm_seq #(
  parameter int MAX_PATTERN = wpm_pkg::MAX_PATTERN_DEF,
  localparam int AW = $clog2(MAX_PATTERN),
  localparam int LW = $clog2(MAX_PATTERN + 1)
) (
  input  logic                        clk,
  input  logic                        rst_n,
  wpm_in_if.sink                      in_ch,
  wpm_out_if.source                   out_ch,
  input  logic                        auth,
  output logic                        ram_we,
  output logic [AW-1:0]               ram_waddr,
  output logic [wpm_pkg::CHAR_W-1:0]  ram_wdata,
  output logic [AW-1:0]               ram_raddr,
  input  logic [wpm_pkg::CHAR_W-1:0]  ram_rdata
);

  typedef enum logic [3:0] {
    ST_IDLE = 4'b0001,
    ST_SUBJ = 4'b0010,
    ST_FIN  = 4'b0100,
    ST_OUT  = 4'b1000
  } state_t;

  state_t                      state_r, state_nxt;
  logic [LW-1:0]               len_r, len_nxt;
  logic [LW-1:0]               cur_r, cur_nxt;
  logic                        any_r, any_nxt;
  logic                        opt_r, opt_nxt;
  wpm_pkg::phase_t             phase_r, phase_nxt;
  logic [wpm_pkg::CHAR_W-1:0]  char_r, char_nxt;
  logic                        auth_r, auth_nxt;
  logic                        fin_b_r, fin_b_nxt;
  logic                        res_r, res_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic                        out_match_r, out_match_nxt;

  logic                        load_ok;
  logic [LW-1:0]               cur_inc;
  logic                        in_range;
  logic                        inc_in_range;
  logic [wpm_pkg::CHAR_W-1:0]  p;
  logic                        hit;

  assign in_ch.ready  = (state_r == ST_IDLE);
  assign out_ch.valid = out_valid_r;
  assign out_ch.match = out_match_r;

  assign load_ok      = int'(in_ch.pattern_pos) < MAX_PATTERN;
  assign cur_inc      = cur_r + LW'(1);
  assign in_range     = cur_r < len_r;
  assign inc_in_range = cur_inc < len_r;
  assign p            = ram_rdata;
  assign hit          = (p == char_r) || ((p == wpm_pkg::CH_QUEST) && auth_r) ||
                        (opt_r && !(any_r && auth_r));

  assign ram_waddr = AW'(in_ch.pattern_pos);
  assign ram_wdata = in_ch.char_value;
  // Read ahead at the next cursor so the store entry is ready next cycle
  assign ram_raddr = cur_nxt[AW-1:0];

  // Sequencer and shared compare step
  always_comb begin
    state_nxt     = state_r;
    len_nxt       = len_r;
    cur_nxt       = cur_r;
    any_nxt       = any_r;
    opt_nxt       = opt_r;
    phase_nxt     = phase_r;
    char_nxt      = char_r;
    auth_nxt      = auth_r;
    fin_b_nxt     = fin_b_r;
    res_nxt       = res_r;
    out_match_nxt = out_match_r;
    out_valid_nxt = out_valid_r;
    ram_we        = 1'b0;

    // Drop the result once taken
    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_IDLE: begin
        if (in_ch.valid) begin
          case (in_ch.func)
            wpm_pkg::FUNC_LOAD: begin
              if (load_ok) begin
                ram_we  = 1'b1;
                len_nxt = LW'(in_ch.pattern_pos) + LW'(1);
                if (in_ch.pattern_pos == '0) begin
                  cur_nxt   = '0;
                  any_nxt   = 1'b0;
                  opt_nxt   = 1'b0;
                  phase_nxt = wpm_pkg::PH_RUN;
                end
              end
            end
            wpm_pkg::FUNC_SUBJ: begin
              case (phase_r)
                wpm_pkg::PH_RUN: begin
                  char_nxt  = in_ch.char_value;
                  auth_nxt  = auth;
                  state_nxt = ST_SUBJ;
                end
                wpm_pkg::PH_TAIL: begin
                  if (!auth) begin
                    phase_nxt = wpm_pkg::PH_FAIL;
                  end
                end
                default: ;
              endcase
            end
            wpm_pkg::FUNC_FIN: begin
              fin_b_nxt = 1'b0;
              state_nxt = ST_FIN;
            end
            default: ;
          endcase
        end
      end

      // One pattern position per cycle for a subject character
      ST_SUBJ: begin
        if (!in_range) begin
          phase_nxt = wpm_pkg::PH_FAIL;
          state_nxt = ST_IDLE;
        end else if (p == wpm_pkg::CH_STAR) begin
          cur_nxt = cur_inc;
          if (!inc_in_range) begin
            phase_nxt = auth_r ? wpm_pkg::PH_TAIL : wpm_pkg::PH_FAIL;
            state_nxt = ST_IDLE;
          end else begin
            any_nxt = 1'b1;
            opt_nxt = 1'b0;
          end
        end else if (p == wpm_pkg::CH_OPT) begin
          cur_nxt = cur_inc;
          opt_nxt = 1'b1;
        end else if (hit) begin
          if (p == char_r) begin
            any_nxt = 1'b0;
          end
          cur_nxt = cur_inc;
          opt_nxt = 1'b0;
          if ((p == char_r) || (p == wpm_pkg::CH_QUEST)) begin
            state_nxt = ST_IDLE;
          end
        end else if (any_r && auth_r) begin
          state_nxt = ST_IDLE;
        end else begin
          phase_nxt = wpm_pkg::PH_FAIL;
          state_nxt = ST_IDLE;
        end
      end

      // Settle fail/tail phases, else resolve trailing '*'/'^' alternating optional and skip checks
      ST_FIN: begin
        if (phase_r == wpm_pkg::PH_FAIL) begin
          res_nxt   = 1'b0;
          state_nxt = ST_OUT;
        end else if (phase_r == wpm_pkg::PH_TAIL) begin
          res_nxt   = 1'b1;
          state_nxt = ST_OUT;
        end else if (!fin_b_r) begin
          if (in_range && (p == wpm_pkg::CH_OPT)) begin
            opt_nxt = 1'b1;
            cur_nxt = cur_inc;
          end
          fin_b_nxt = 1'b1;
        end else if ((in_range && (p == wpm_pkg::CH_STAR)) || opt_r) begin
          cur_nxt   = cur_inc;
          opt_nxt   = 1'b0;
          fin_b_nxt = 1'b0;
        end else begin
          res_nxt   = !in_range;
          state_nxt = ST_OUT;
        end
      end

      // Hand the verdict to the output register and clear the match state
      ST_OUT: begin
        if (!out_valid_r || out_ch.ready) begin
          out_valid_nxt = 1'b1;
          out_match_nxt = res_r;
          cur_nxt       = '0;
          any_nxt       = 1'b0;
          opt_nxt       = 1'b0;
          phase_nxt     = wpm_pkg::PH_RUN;
          state_nxt     = ST_IDLE;
        end
      end

      default: state_nxt = ST_IDLE;
    endcase
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      len_r       <= '0;
      cur_r       <= '0;
      any_r       <= 1'b0;
      opt_r       <= 1'b0;
      phase_r     <= wpm_pkg::PH_RUN;
      fin_b_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      len_r       <= len_nxt;
      cur_r       <= cur_nxt;
      any_r       <= any_nxt;
      opt_r       <= opt_nxt;
      phase_r     <= phase_nxt;
      fin_b_r     <= fin_b_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload
  always_ff @(posedge clk) begin
    char_r      <= char_nxt;
    auth_r      <= auth_nxt;
    res_r       <= res_nxt;
    out_match_r <= out_match_nxt;
  end

endmodule

// File: rtl/core/wildcard_pattern_matcher.sv
// Loads, ignored requests and subject characters after a failure or a trailing '*' are
// handled in the idle state. Any other subject character moves on to examine pattern
// positions in turn (1 to L+1, L the pattern length). A finish resolves trailing '^'/'*'
// and then loads the output register, held while an earlier verdict waits. The store gives
// one registered read per cycle to the compare step.
// rst_n (synchronous, active low) clears match state, length and config regs, not the store.
module wildcard_pattern_matcher #(
  parameter int MAX_PATTERN = wpm_pkg::MAX_PATTERN_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  wpm_in_if.sink                      in_ch,
  wpm_out_if.source                   out_ch,
  input  logic                        cfg_psel,
  input  logic                        cfg_penable,
  input  logic                        cfg_pwrite,
  input  logic [wpm_pkg::CFG_AW-1:0]  cfg_paddr,
  input  logic [wpm_pkg::CFG_DW-1:0]  cfg_pwdata,
  output logic [wpm_pkg::CFG_DW-1:0]  cfg_prdata,
  output logic                        cfg_pready
);

  localparam int AW = $clog2(MAX_PATTERN);

  logic                        auth;
  logic                        ram_we;
  logic [AW-1:0]               ram_waddr;
  logic [wpm_pkg::CHAR_W-1:0]  ram_wdata;
  logic [AW-1:0]               ram_raddr;
  logic [wpm_pkg::CHAR_W-1:0]  ram_rdata;

  // Configuration registers and authorised-set lookup
  wpm_cfg u_cfg (
    .clk        (clk),
    .rst_n      (rst_n),
    .psel       (cfg_psel),
    .penable    (cfg_penable),
    .pwrite     (cfg_pwrite),
    .paddr      (cfg_paddr),
    .pwdata     (cfg_pwdata),
    .prdata     (cfg_prdata),
    .pready     (cfg_pready),
    .query_char (in_ch.char_value),
    .query_auth (auth)
  );

  // Pattern store
  wpm_ram #(
    .WIDTH (wpm_pkg::CHAR_W),
    .DEPTH (MAX_PATTERN)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Match sequencer
  wpm_seq #(
    .MAX_PATTERN (MAX_PATTERN)
  ) u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .auth      (auth),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata)
  );

endmodule
